@@ design/sida_pkg.sv @@
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types, constants and helpers for the signed decimal ASCII renderer.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int NUM_DIGITS = 10;
  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int WIDE_W     = VALUE_W + DIGIT_W;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // digits[NUM_DIGITS-1] is the most significant digit once all cells passed
  typedef struct packed {
    logic                              neg;
    logic [VALUE_W-1:0]                mag;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
  } sida_word_t;

  function automatic logic [VALUE_W-1:0] pow10(input int k);
    logic [VALUE_W-1:0] p;
    p = VALUE_W'(1);
    for (int i = 0; i < k; i++) begin
      p = VALUE_W'(p * VALUE_W'(10));
    end
    return p;
  endfunction

endpackage

@@ design/sida_if.sv @@
// ----------------------------------------------------------------------------
// sida_in_if / sida_out_if
// Valid/ready channels: integer beats in, character beats out.
// ----------------------------------------------------------------------------
interface sida_in_if import sida_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sida_out_if import sida_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ design/sida_cell.sv @@
// ----------------------------------------------------------------------------
// sida_cell
// One digit cell: extracts the digit for its power of ten and passes the
// remainder and collected digits to the next cell.
// ----------------------------------------------------------------------------
module sida_cell import sida_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [VALUE_W-1:0] weight,
  input  logic               in_valid,
  output logic               in_ready,
  input  sida_word_t         in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output sida_word_t         out_word
);

  logic               valid_r;
  sida_word_t         word_r;
  sida_word_t         word_nxt;
  logic [WIDE_W-1:0]  mult;
  logic [DIGIT_W-1:0] digit;
  logic [VALUE_W-1:0] sub;

  always_comb begin
    digit = '0;
    sub   = '0;
    mult  = '0;
    for (int m = 1; m < 10; m++) begin
      mult = WIDE_W'(m) * {{DIGIT_W{1'b0}}, weight};
      if ({{DIGIT_W{1'b0}}, in_word.mag} >= mult) begin
        digit = DIGIT_W'(m);
        sub   = mult[VALUE_W-1:0];
      end
    end
    word_nxt.neg    = in_word.neg;
    word_nxt.mag    = in_word.mag - sub;
    word_nxt.digits = {in_word.digits[NUM_DIGITS-2:0], digit};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

@@ design/sida_emit.sv @@
// ----------------------------------------------------------------------------
// sida_emit
// Character serializer: sign, then digits from the leading nonzero one.
// ----------------------------------------------------------------------------
module sida_emit import sida_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sida_word_t in_word,
  sida_out_if.source out_bus
);

  logic                               valid_r;
  logic                               sign_r;
  logic [IDX_W-1:0]                   idx_r;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_r;
  logic [IDX_W-1:0]                   lead;
  logic                               last_w;

  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_word.digits[i] != '0) begin
        lead = IDX_W'(i);
      end
    end
  end

  assign last_w            = !sign_r && (idx_r == '0);
  assign in_ready          = !valid_r || (out_bus.ready && last_w);
  assign out_bus.valid     = valid_r;
  assign out_bus.last      = last_w;
  assign out_bus.character = sign_r ? CHAR_MINUS
                                    : CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_r[idx_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready) begin
      sign_r   <= in_word.neg;
      idx_r    <= lead;
      digits_r <= in_word.digits;
    end else if (out_bus.ready) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        idx_r <= idx_r - IDX_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.character == CHAR_MINUS) ||
                      ((out_bus.character >= CHAR_ZERO) &&
                       (out_bus.character <= CHAR_ZERO + CHAR_W'(9))))
    else $error("illegal character on output");
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.character == CHAR_MINUS) |-> !out_bus.last)
    else $error("minus sign flagged as last");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r < IDX_W'(NUM_DIGITS)))
    else $error("digit index out of range");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !sign_r && out_bus.ready && !last_w) |=> (idx_r == $past(idx_r) - IDX_W'(1)))
    else $error("digit index did not step");
`endif

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Renders a signed 32-bit integer as decimal ASCII, one character per beat.
// ----------------------------------------------------------------------------
// Each value beat becomes 1 to 11 character beats: '-' for a negative value,
// then the digits without leading zeros ('0' for zero); last marks the final
// character. A row of ten digit cells, one per power of ten, takes a value
// every cycle unless output back-pressure stalls it; a value passes the ten
// cell registers and the emitter register before its first character appears.
// Intake is paced by the single output port and each value's 1 to 11 characters.
module signed_int_to_decimal_ascii import sida_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sida_in_if.sink   in_bus,
  sida_out_if.source out_bus
);

  logic       valid_c [NUM_DIGITS+1];
  logic       ready_c [NUM_DIGITS+1];
  sida_word_t word_c  [NUM_DIGITS+1];
  logic [VALUE_W-1:0] raw;

  assign raw              = in_bus.value;
  assign valid_c[0]       = in_bus.valid;
  assign in_bus.ready     = ready_c[0];
  assign word_c[0].neg    = raw[VALUE_W-1];
  assign word_c[0].mag    = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
  assign word_c[0].digits = '0;

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    sida_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .weight    (pow10(NUM_DIGITS - 1 - k)),
      .in_valid  (valid_c[k]),
      .in_ready  (ready_c[k]),
      .in_word   (word_c[k]),
      .out_valid (valid_c[k+1]),
      .out_ready (ready_c[k+1]),
      .out_word  (word_c[k+1])
    );
  end

  sida_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (valid_c[NUM_DIGITS]),
    .in_ready (ready_c[NUM_DIGITS]),
    .in_word  (word_c[NUM_DIGITS]),
    .out_bus  (out_bus)
  );

endmodule
